FILE: hdl/assert_macros.svh
// Assertion helpers used by the integer_literal_parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ILP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ILP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hdl/ilp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilp_pkg
// Types and constants of the integer literal parser.
// ----------------------------------------------------------------------------
package ilp_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_word_t;

  typedef struct packed {
    logic               is_number;
    logic signed [63:0] number_value;
    logic               too_big;
  } out_word_t;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_BIN = 2'd1,
    RADIX_OCT = 2'd2,
    RADIX_HEX = 2'd3
  } radix_e;

  // multiply-add result with carry-out past 64 bits
  typedef struct packed {
    logic [63:0] acc;
    logic        ovf;
  } mac_res_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LL    = 8'h6C;
  localparam logic [7:0] CH_UL    = 8'h4C;
  localparam logic [7:0] CH_LU    = 8'h75;
  localparam logic [7:0] CH_UU    = 8'h55;
  localparam logic [7:0] CH_APOS  = 8'h27;

  localparam logic [63:0] SIGNED_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  // "true"
  function automatic logic [7:0] true_char(input logic [1:0] p);
    logic [7:0] c;
    case (p)
      2'd0:    c = 8'h74;
      2'd1:    c = 8'h72;
      2'd2:    c = 8'h75;
      default: c = 8'h65;
    endcase
    return c;
  endfunction

  // "false"
  function automatic logic [7:0] false_char(input logic [2:0] p);
    logic [7:0] c;
    case (p)
      3'd0:    c = 8'h66;
      3'd1:    c = 8'h61;
      3'd2:    c = 8'h6C;
      3'd3:    c = 8'h73;
      default: c = 8'h65;
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/ilp_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilp_mac
// acc * base + digit by shift-add, with carry-out past 64 bits.
// ----------------------------------------------------------------------------
module ilp_mac (
  input  logic [63:0]      acc_i,
  input  ilp_pkg::radix_e  radix_i,
  input  logic [3:0]       digit_i,
  output ilp_pkg::mac_res_t res_o
);

  logic [67:0] acc_w;
  logic [67:0] prod;
  logic [67:0] sum;

  assign acc_w = {4'b0000, acc_i};

  always_comb begin
    case (radix_i)
      ilp_pkg::RADIX_DEC: prod = (acc_w << 3) + (acc_w << 1);
      ilp_pkg::RADIX_BIN: prod = acc_w << 1;
      ilp_pkg::RADIX_OCT: prod = acc_w << 3;
      ilp_pkg::RADIX_HEX: prod = acc_w << 4;
      default:            prod = acc_w;
    endcase
  end

  assign sum        = prod + {64'd0, digit_i};
  assign res_o.acc  = sum[63:0];
  assign res_o.ovf  = |sum[67:64];

endmodule

FILE: hdl/ilp_token.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilp_token
// Per-token state and the one-character step; gives the result at the last
// character and clears the token state.
// ----------------------------------------------------------------------------
module ilp_token (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  ilp_pkg::in_word_t   word_i,
  input  logic                c_mode_i,
  output ilp_pkg::out_word_t  res_o
);

  logic [2:0]       pos_q, pos_d;
  ilp_pkg::radix_e  radix_q, radix_d;
  logic [63:0]      acc_q, acc_d;
  logic             sat_q, sat_d;
  logic             uns_q, uns_d;
  logic             suf_q, suf_d;
  logic             bad_q, bad_d;
  logic [1:0]       wm_q, wm_d;

  logic [7:0]        c;
  logic              is_dec, is_hex;
  logic [3:0]        dval;
  logic              dig_ok;
  logic              num_en;
  logic              first_zero;
  ilp_pkg::radix_e   mac_radix;
  ilp_pkg::mac_res_t mac;

  function automatic logic [1:0] word_next(input logic [2:0] p, input logic [7:0] ch,
                                           input logic [1:0] wm);
    logic [1:0] r;
    r = wm;
    if (p >= 3'd4 || ch != ilp_pkg::true_char(p[1:0])) r[0] = 1'b0;
    if (p >= 3'd5 || ch != ilp_pkg::false_char(p)) r[1] = 1'b0;
    return r;
  endfunction

  assign c      = word_i.char_code;
  assign is_dec = (c >= ilp_pkg::CH_ZERO) && (c <= ilp_pkg::CH_NINE);

  always_comb begin
    is_hex = 1'b1;
    dval   = 4'd0;
    if (is_dec) begin
      dval = 4'(c - ilp_pkg::CH_ZERO);
    end else if (c >= ilp_pkg::CH_LA && c <= ilp_pkg::CH_LF) begin
      dval = 4'(c - ilp_pkg::CH_LA + 8'd10);
    end else if (c >= ilp_pkg::CH_UA && c <= ilp_pkg::CH_UF) begin
      dval = 4'(c - ilp_pkg::CH_UA + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  // second char after a leading zero that is not b/x switches to octal
  assign first_zero = (pos_q == 3'd1) && (acc_q == 64'd0);
  assign mac_radix  = first_zero ? ilp_pkg::RADIX_OCT : radix_q;

  always_comb begin
    case (mac_radix)
      ilp_pkg::RADIX_DEC: dig_ok = is_hex && (dval <= 4'd9);
      ilp_pkg::RADIX_BIN: dig_ok = is_hex && (dval <= 4'd1);
      ilp_pkg::RADIX_OCT: dig_ok = is_hex && (dval <= 4'd7);
      default:            dig_ok = is_hex;
    endcase
  end

  ilp_mac u_mac (
    .acc_i   (acc_q),
    .radix_i (mac_radix),
    .digit_i (dval),
    .res_o   (mac)
  );

  always_comb begin
    radix_d = radix_q;
    acc_d   = acc_q;
    sat_d   = sat_q;
    uns_d   = uns_q;
    suf_d   = suf_q;
    bad_d   = bad_q;
    wm_d    = wm_q;
    num_en  = 1'b0;
    pos_d   = (pos_q == 3'd7) ? pos_q : pos_q + 3'd1;

    if (pos_q == 3'd0) begin
      if (is_dec) begin
        wm_d    = 2'b00;
        radix_d = ilp_pkg::RADIX_DEC;
        acc_d   = {60'd0, dval};
      end else begin
        wm_d  = word_next(pos_q, c, 2'b11);
        bad_d = (wm_d == 2'b00);
      end
    end else if (bad_q) begin
      // verdict is final
    end else if (wm_q != 2'b00) begin
      wm_d  = word_next(pos_q, c, wm_q);
      bad_d = (wm_d == 2'b00);
    end else if (!suf_q) begin
      if (first_zero) begin
        if (c == ilp_pkg::CH_LB || c == ilp_pkg::CH_UB) begin
          radix_d = ilp_pkg::RADIX_BIN;
        end else if (c == ilp_pkg::CH_LX || c == ilp_pkg::CH_UX) begin
          radix_d = ilp_pkg::RADIX_HEX;
        end else begin
          radix_d = ilp_pkg::RADIX_OCT;
          num_en  = 1'b1;
        end
      end else begin
        num_en = 1'b1;
      end
    end

    if (num_en) begin
      if (c == ilp_pkg::CH_APOS) begin
        // separator
      end else if (c == ilp_pkg::CH_LL || c == ilp_pkg::CH_UL) begin
        suf_d = 1'b1;
      end else if (c == ilp_pkg::CH_LU || c == ilp_pkg::CH_UU) begin
        suf_d = 1'b1;
        uns_d = 1'b1;
      end else if (!dig_ok) begin
        bad_d = 1'b1;
      end else if (!sat_q) begin
        if (mac.ovf) begin
          sat_d = 1'b1;
          acc_d = '1;
        end else begin
          acc_d = mac.acc;
        end
      end
    end
  end

  // result from the post-step state
  always_comb begin
    res_o = '0;
    if (!bad_d) begin
      if (wm_d != 2'b00) begin
        if (!c_mode_i) begin
          if (wm_d[0] && pos_q == 3'd3) begin
            res_o.is_number    = 1'b1;
            res_o.number_value = 64'sd1;
          end else if (wm_d[1] && pos_q == 3'd4) begin
            res_o.is_number = 1'b1;
          end
        end
      end else begin
        res_o.is_number = 1'b1;
        if (uns_d) begin
          res_o.number_value = acc_d;
          res_o.too_big      = acc_d[63];
        end else begin
          res_o.number_value = (sat_d || acc_d[63]) ? ilp_pkg::SIGNED_MAX : acc_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 3'd0;
      radix_q <= ilp_pkg::RADIX_DEC;
      acc_q   <= 64'd0;
      sat_q   <= 1'b0;
      uns_q   <= 1'b0;
      suf_q   <= 1'b0;
      bad_q   <= 1'b0;
      wm_q    <= 2'b11;
    end else if (step_i) begin
      if (word_i.last_char) begin
        pos_q   <= 3'd0;
        radix_q <= ilp_pkg::RADIX_DEC;
        acc_q   <= 64'd0;
        sat_q   <= 1'b0;
        uns_q   <= 1'b0;
        suf_q   <= 1'b0;
        bad_q   <= 1'b0;
        wm_q    <= 2'b11;
      end else begin
        pos_q   <= pos_d;
        radix_q <= radix_d;
        acc_q   <= acc_d;
        sat_q   <= sat_d;
        uns_q   <= uns_d;
        suf_q   <= suf_d;
        bad_q   <= bad_d;
        wm_q    <= wm_d;
      end
    end
  end

endmodule

FILE: hdl/integer_literal_parser.sv
// A token's result appears in the result register in the cycle after its last character steps.
// Throughput: one character per cycle unless the input stalls; the per-character step (one shift-add
// multiply-add and carry check) is a single register-to-register pass.
// The input register stalls only when a last character meets a stalled result.
// Reset (rst_ni low, async) empties both registers, clears token state, c_mode=0.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_literal_parser
// Streams token characters, gives one integer/word verdict per token.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module integer_literal_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ilp_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ilp_pkg::out_word_t  out_word_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i
);

  logic               inp_valid_q;
  ilp_pkg::in_word_t  inp_word_q;
  logic               out_valid_q;
  ilp_pkg::out_word_t out_word_q;
  logic               c_mode_q;
  logic               out_free;
  logic               step;
  logic               fin;
  ilp_pkg::out_word_t res;

  assign out_free    = !out_valid_q || !out_stall_i;
  // a last char needs room in the result register
  assign step        = inp_valid_q && (!inp_word_q.last_char || out_free);
  assign fin         = step && inp_word_q.last_char;
  assign in_stall_o  = inp_valid_q && !step;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      c_mode_q    <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        inp_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= fin;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        c_mode_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      inp_word_q <= in_word_i;
    end
    if (fin) begin
      out_word_q <= res;
    end
  end

  ilp_token u_token (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .word_i   (inp_word_q),
    .c_mode_i (c_mode_q),
    .res_o    (res)
  );

  `ILP_ASSERT_IMP(a_stall_only_last, clk_i, rst_ni, in_stall_o, inp_valid_q && inp_word_q.last_char)
  `ILP_ASSERT_NXT(a_fin_to_out, clk_i, rst_ni, fin, out_valid_o)
  `ILP_ASSERT_IMP(a_bad_is_zero, clk_i, rst_ni, out_valid_o && !out_word_o.is_number, out_word_o.number_value == 64'sd0 && !out_word_o.too_big)
  `ILP_ASSERT_IMP(a_big_negative, clk_i, rst_ni, out_valid_o && out_word_o.too_big, out_word_o.number_value[63] && out_word_o.is_number)

endmodule

FILE: tb/sv/integer_literal_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_literal_parser_tb
// Feeds tokens one character word at a time: a few hand-picked literals and
// words, then random numerals, words, broken numerals and noise under random
// idling on both channels. A scoreboard parses every accepted character on
// its own and checks each token verdict. The word-mode register is flipped
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module integer_literal_parser_tb;

  localparam int unsigned IDLE_LIMIT = 4000;
  localparam string TRUE_TXT  = "true";
  localparam string FALSE_TXT = "false";

  // token parser kept in step with the block; one verdict per token
  class lit_scoreboard;
    bit                 word_off;
    logic [2:0]         pos;
    ilp_pkg::radix_e    radix;
    logic [63:0]        acc;
    bit                 sat, uns, sfx, bad;
    logic [1:0]         wmatch;
    ilp_pkg::out_word_t verdicts_due[$];
    int unsigned        n_err;

    function new();
      word_off = 1'b0;
      n_err = 0;
      clear_token();
    endfunction

    function void clear_token();
      pos = 3'd0;
      radix = ilp_pkg::RADIX_DEC;
      acc = '0;
      sat = 1'b0;
      uns = 1'b0;
      sfx = 1'b0;
      bad = 1'b0;
      wmatch = 2'b11;
    endfunction

    function void flag(string msg);
      n_err++;
      if (n_err <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function int unsigned digit_of(logic [7:0] c);
      if (c >= ilp_pkg::CH_ZERO && c <= ilp_pkg::CH_NINE) return c - ilp_pkg::CH_ZERO;
      if (c >= ilp_pkg::CH_LA && c <= ilp_pkg::CH_LF) return c - ilp_pkg::CH_LA + 10;
      if (c >= ilp_pkg::CH_UA && c <= ilp_pkg::CH_UF) return c - ilp_pkg::CH_UA + 10;
      return 99;
    endfunction

    function void word_step(logic [7:0] c);
      if (pos >= 4 || c != TRUE_TXT[pos]) wmatch[0] = 1'b0;
      if (pos >= 5 || c != FALSE_TXT[pos]) wmatch[1] = 1'b0;
      if (wmatch == 2'b00) bad = 1'b1;
    endfunction

    function void numeral_step(logic [7:0] c);
      logic [63:0] base;
      int unsigned d;
      case (radix)
        ilp_pkg::RADIX_BIN: base = 64'd2;
        ilp_pkg::RADIX_OCT: base = 64'd8;
        ilp_pkg::RADIX_HEX: base = 64'd16;
        default:            base = 64'd10;
      endcase
      if (c == ilp_pkg::CH_APOS) return;
      if (c == ilp_pkg::CH_LL || c == ilp_pkg::CH_UL) begin
        sfx = 1'b1;
        return;
      end
      if (c == ilp_pkg::CH_LU || c == ilp_pkg::CH_UU) begin
        sfx = 1'b1;
        uns = 1'b1;
        return;
      end
      d = digit_of(c);
      if (64'(d) >= base) begin
        bad = 1'b1;
        return;
      end
      if (sat) return;
      if (acc > (64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) / base) begin
        sat = 1'b1;
        acc = '1;
      end else begin
        acc = acc * base + 64'(d);
      end
    endfunction

    function void parse_char(ilp_pkg::in_word_t w);
      logic [7:0]         c;
      bit                 ok, big;
      logic [63:0]        val;
      ilp_pkg::out_word_t v;
      c = w.char_code;
      if (pos == 3'd0) begin
        if (c >= ilp_pkg::CH_ZERO && c <= ilp_pkg::CH_NINE) begin
          wmatch = 2'b00;
          radix = ilp_pkg::RADIX_DEC;
          acc = 64'(c - ilp_pkg::CH_ZERO);
        end else begin
          wmatch = 2'b11;
          word_step(c);
        end
      end else if (!bad) begin
        if (wmatch != 2'b00) begin
          word_step(c);
        end else if (!sfx) begin
          // a leading zero picks the base from the second character
          if (pos == 3'd1 && acc == 64'd0) begin
            if (c == ilp_pkg::CH_LB || c == ilp_pkg::CH_UB) radix = ilp_pkg::RADIX_BIN;
            else if (c == ilp_pkg::CH_LX || c == ilp_pkg::CH_UX) radix = ilp_pkg::RADIX_HEX;
            else begin
              radix = ilp_pkg::RADIX_OCT;
              numeral_step(c);
            end
          end else begin
            numeral_step(c);
          end
        end
      end
      if (!w.last_char) begin
        if (pos != 3'd7) pos++;
        return;
      end
      ok = 1'b0;
      big = 1'b0;
      val = '0;
      if (!bad) begin
        if (wmatch != 2'b00) begin
          if (!word_off) begin
            if (wmatch[0] && pos == 3'd3) begin
              ok = 1'b1;
              val = 64'd1;
            end else if (wmatch[1] && pos == 3'd4) begin
              ok = 1'b1;
            end
          end
        end else begin
          ok = 1'b1;
          if (uns) begin
            val = sat ? '1 : acc;
            big = val > ilp_pkg::SIGNED_MAX;
          end else begin
            val = (sat || acc > ilp_pkg::SIGNED_MAX) ? ilp_pkg::SIGNED_MAX : acc;
          end
        end
      end
      v.is_number = ok;
      v.number_value = val;
      v.too_big = big;
      verdicts_due.insert(verdicts_due.size(), v);
      clear_token();
    endfunction

    function void check_verdict(ilp_pkg::out_word_t got);
      ilp_pkg::out_word_t want;
      if (verdicts_due.size() == 0) begin
        flag($sformatf("result with none pending: num=%0b val=%0d big=%0b",
                       got.is_number, got.number_value, got.too_big));
        return;
      end
      want = verdicts_due.pop_front();
      if (got.is_number !== want.is_number || got.number_value !== want.number_value ||
          got.too_big !== want.too_big)
        flag($sformatf("got num=%0b val=%0d big=%0b, want num=%0b val=%0d big=%0b",
                       got.is_number, got.number_value, got.too_big,
                       want.is_number, want.number_value, want.too_big));
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  ilp_pkg::in_word_t  in_word_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  ilp_pkg::out_word_t out_word_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_data_i = 1'b0;

  lit_scoreboard sb = new();
  logic [7:0]    tok_chars[$];
  bit            in_idle_on;
  int unsigned   rand_chars;
  int unsigned   stall_left, out_mode, mode_age, idle_cnt;

  integer_literal_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side back-pressure; the stall mode is re-drawn whenever its age counter runs out
  always @(posedge clk_i) begin
    if (mode_age == 0) begin
      out_mode = $urandom_range(0, 3);
      mode_age = $urandom_range(20, 120);
    end else begin
      mode_age--;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if (out_mode != 0) stall_left = idle_len();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_verdict(out_word_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cnt = 0;
    end else begin
      idle_cnt++;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("TIMEOUT: no handshake for %0d cycles", IDLE_LIMIT);
        $display("integer_literal_parser_tb: errors");
        $finish;
      end
    end
  end

  function automatic void add_char(input logic [7:0] c);
    tok_chars.insert(tok_chars.size(), c);
  endfunction

  task automatic send_char(input logic [7:0] c, input logic is_last);
    int unsigned       gap;
    ilp_pkg::in_word_t w;
    gap = in_idle_on ? idle_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    w.char_code = c;
    w.last_char = is_last;
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    sb.parse_char(w);
  endtask

  task automatic send_token();
    in_idle_on = ($urandom_range(0, 3) != 0);
    foreach (tok_chars[i]) send_char(tok_chars[i], i == tok_chars.size() - 1);
    tok_chars.delete();
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
    send_token();
  endtask

  // hold off until every verdict is in and the pipe has emptied
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.verdicts_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.word_off = v;
  endtask

  function automatic logic [7:0] rand_digit(ilp_pkg::radix_e r);
    int unsigned v;
    case (r)
      ilp_pkg::RADIX_BIN: return ilp_pkg::CH_ZERO + 8'($urandom_range(0, 1));
      ilp_pkg::RADIX_OCT: return ilp_pkg::CH_ZERO + 8'($urandom_range(0, 7));
      ilp_pkg::RADIX_HEX: begin
        v = $urandom_range(0, 21);
        if (v < 10) return ilp_pkg::CH_ZERO + 8'(v);
        if (v < 16) return ilp_pkg::CH_LA + 8'(v - 10);
        return ilp_pkg::CH_UA + 8'(v - 16);
      end
      default: return ilp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    endcase
  endfunction

  function automatic void build_numeral();
    ilp_pkg::radix_e r;
    int unsigned     n;
    logic [7:0]      sfx_set[4];
    sfx_set = '{ilp_pkg::CH_LU, ilp_pkg::CH_UU, ilp_pkg::CH_LL, ilp_pkg::CH_UL};
    r = ilp_pkg::radix_e'($urandom_range(0, 3));
    case (r)
      ilp_pkg::RADIX_DEC: add_char(ilp_pkg::CH_ZERO + 8'($urandom_range(1, 9)));
      ilp_pkg::RADIX_OCT: add_char(ilp_pkg::CH_ZERO);
      ilp_pkg::RADIX_BIN: begin
        add_char(ilp_pkg::CH_ZERO);
        add_char($urandom_range(0, 1) ? ilp_pkg::CH_LB : ilp_pkg::CH_UB);
      end
      default: begin
        add_char(ilp_pkg::CH_ZERO);
        add_char($urandom_range(0, 1) ? ilp_pkg::CH_LX : ilp_pkg::CH_UX);
      end
    endcase
    // long runs push past 64 bits
    if ($urandom_range(0, 99) < 15) n = (r == ilp_pkg::RADIX_BIN) ? $urandom_range(60, 68)
                                                                 : $urandom_range(10, 24);
    else n = $urandom_range(0, 6);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) add_char(ilp_pkg::CH_APOS);
      add_char(rand_digit(r));
    end
    if ($urandom_range(0, 9) < 4) begin
      repeat ($urandom_range(1, 3)) add_char(sfx_set[$urandom_range(0, 3)]);
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 4)) add_char(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void build_random_token();
    int unsigned k;
    string       w;
    k = $urandom_range(0, 99);
    if (k < 50) begin
      build_numeral();
    end else if (k < 70) begin
      w = $urandom_range(0, 1) ? TRUE_TXT : FALSE_TXT;
      for (int i = 0; i < w.len(); i++) add_char(w[i]);
      case ($urandom_range(0, 9))
        6: void'(tok_chars.pop_back());
        7: add_char(8'($urandom_range(0, 255)));
        8: tok_chars[$urandom_range(0, w.len() - 1)] = 8'($urandom_range(8'h61, 8'h7A));
        9: tok_chars[$urandom_range(0, w.len() - 1)] = 8'($urandom_range(0, 255));
        default: ;
      endcase
    end else if (k < 85) begin
      build_numeral();
      tok_chars[$urandom_range(0, tok_chars.size() - 1)] = 8'($urandom_range(0, 255));
    end else begin
      repeat ($urandom_range(1, 6)) add_char(8'($urandom_range(0, 255)));
    end
  endfunction

  initial begin
    string dir_toks[$];
    dir_toks = '{"0", "7", "9", "0x", "0B", "0u", "0b1011", "0XdeadBEEF", "0777", "08",
                 "0b102", "1'000'000", "123uLjunk!", "42l", "9223372036854775807",
                 "9223372036854775808", "18446744073709551615u", "18446744073709551616U",
                 "0xFFFFFFFFFFFFFFFFFFu", "true", "false", "tru", "trUe", "falsey", "xyz"};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_mode(1'b0);

    foreach (dir_toks[i]) send_text(dir_toks[i]);
    // NUL inside a numeral, a lone top-of-range byte
    add_char(ilp_pkg::CH_ZERO + 8'd1);
    add_char(8'h00);
    send_token();
    add_char(8'hFF);
    send_token();

    drain();
    write_mode(1'b1);
    send_text(TRUE_TXT);
    send_text(FALSE_TXT);
    send_text("0x1fu");

    rand_chars = 0;
    for (int p = 0; p < 6; p++) begin
      drain();
      write_mode(p[0]);
      while (rand_chars < (p + 1) * 290) begin
        build_random_token();
        rand_chars += tok_chars.size();
        send_token();
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    while (sb.verdicts_due.size() != 0) begin
      sb.flag($sformatf("verdict never came: num=%0b val=%0d",
                        sb.verdicts_due[0].is_number,
                        sb.verdicts_due[0].number_value));
      void'(sb.verdicts_due.pop_front());
    end
    if (sb.n_err == 0) begin
      $display("integer_literal_parser_tb: clean");
    end else begin
      $display("integer_literal_parser_tb: errors");
    end
    $finish;
  end

endmodule

FILE: integer_literal_parser.f
+incdir+hdl
hdl/ilp_pkg.sv
hdl/ilp_mac.sv
hdl/ilp_token.sv
hdl/integer_literal_parser.sv
tb/sv/integer_literal_parser_tb.sv
